// File: rtl/core/prtt_pkg.sv
// ----------------------------------------------------------------------------
// prtt_pkg - probe request tracking table shared definitions
// Table sizes, word layouts, register indexes and name helpers.
// ----------------------------------------------------------------------------
package prtt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int NAME_BYTES    = 32;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W = 48;
    localparam int LEN_W  = 6;
    localparam int WORD_W = 64;
    localparam int NAME_W = 4 * WORD_W;
    localparam int KNAME_W = 8 * NAME_BYTES;
    localparam int KEY_W  = ADDR_W + LEN_W + KNAME_W;
    localparam int CHAN_W = 4;
    localparam int SIG_W  = 8;
    localparam int TIME_W = 32;
    localparam int CTR_W  = 32;
    localparam int INFO_W = TIME_W + SIG_W + CHAN_W;

    localparam int OIDX_W  = 6;
    localparam int OUSED_W = 7;

    localparam int IN_BITS  = ADDR_W + LEN_W + NAME_W + CHAN_W + SIG_W + TIME_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + OIDX_W + 1 + 1 + CTR_W + OUSED_W + CTR_W + CTR_W + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPTURE = CFG_IDX_W'(0),
        CFG_RECORD  = CFG_IDX_W'(1)
    } t_cfg_reg;

    // Saturate a name length at the largest name held
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        if (len > LEN_W'(NAME_BYTES)) begin
            return LEN_W'(NAME_BYTES);
        end
        return len;
    endfunction

    // Keep the leading len bytes of the name, zero the rest
    function automatic logic [KNAME_W-1:0] mask_name(input logic [NAME_W-1:0] name,
                                                     input logic [LEN_W-1:0]  len);
        logic [KNAME_W-1:0] res;
        for (int b = 0; b < NAME_BYTES; b++) begin
            res[8*b +: 8] = (LEN_W'(b) < len) ? name[8*b +: 8] : 8'h00;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/prtt_ram.sv
// ----------------------------------------------------------------------------
// prtt_ram - generic single write, single read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module prtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/probe_request_tracking_table_top.sv
// ----------------------------------------------------------------------------
// probe_request_tracking_table_top - probe request tracking table
// Linear exact-match search of a 64-entry table per probe request word,
// hit update or append, running frame and overflow totals.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         i_s_axis_tvalid/o_tready   one parsed probe request
//  m_axis    out        o_m_axis_tvalid/i_tready   one result per request
//  cfg       in         i_cfg_valid/o_cfg_ready    register index + data
//
//  Search: the key RAM is read one entry a cycle through a single compare unit,
//  walking the used entries in order; a hit ends the walk early; when capture
//  is off the word skips the search and goes straight to the output state.
//  The input is ready only when the sequencer is idle.
//  A finished result waits in the output register; the next word is taken
//  meanwhile, and its result waits until the previous one is taken.
//  Reset clears the counters and the used count; table RAMs are not cleared.
// ----------------------------------------------------------------------------
module probe_request_tracking_table_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // addr[47:0] name_length[53:48] name_word0..3[309:54]
    // rx_channel[313:310] signal_dbm[321:314] time_seconds[353:322]
    input  logic [prtt_pkg::IN_W-1:0]         i_s_axis_tdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // accepted[0] entry_index[6:1] is_new_entry[7] table_full[8]
    // entry_hits[40:9] entries_used[47:41] frames_total[79:48]
    // overflow_total[111:80] record_frame[112]
    output logic [prtt_pkg::OUT_W-1:0]        o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [prtt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prtt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import prtt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic                r_capture_en;
    logic                r_record_en;
    logic [KEY_W-1:0]    r_key;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_ptr;
    logic                r_pend;
    logic [IDX_W-1:0]    r_cand;
    logic [IDX_W-1:0]    r_idx;
    logic [CTR_W-1:0]    r_hits;
    logic                r_acc;
    logic                r_fresh;
    logic                r_full;
    logic                r_store;
    logic [CTR_W-1:0]    r_frames;
    logic [CTR_W-1:0]    r_overflow;
    logic                r_m_tvalid;
    logic [OUT_BITS-1:0] r_m_tdata;

    logic                s_accept;
    logic                out_free;
    logic [LEN_W-1:0]    in_len;
    logic [KEY_W-1:0]    in_key;
    logic [KEY_W-1:0]    key_rd;
    logic [CTR_W-1:0]    hits_rd;
    logic                key_hit;
    logic [IDX_W-1:0]    rd_addr;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_tvalid || i_m_axis_tready;

    assign in_len = sat_len(i_s_axis_tdata[ADDR_W +: LEN_W]);
    assign in_key = {mask_name(i_s_axis_tdata[ADDR_W+LEN_W +: NAME_W], in_len),
                     in_len, i_s_axis_tdata[0 +: ADDR_W]};

    assign rd_addr = r_ptr[IDX_W-1:0];
    assign key_hit = r_pend && (key_rd == r_key);

    prtt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_WRITE) && r_fresh),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_rd)
    );

    prtt_ram #(.WIDTH(CTR_W), .DEPTH(TABLE_ENTRIES)) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_WRITE) && r_store),
        .i_waddr (r_idx),
        .i_wdata (r_hits),
        .i_raddr (rd_addr),
        .o_rdata (hits_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_capture_en <= 1'b0;
            r_record_en  <= 1'b0;
            r_used       <= '0;
            r_frames     <= '0;
            r_overflow   <= '0;
            r_m_tvalid   <= 1'b0;
            r_pend       <= 1'b0;
            r_ptr        <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CAPTURE: r_capture_en <= i_cfg_data[0];
                    CFG_RECORD:  r_record_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // drop the taken word unless a new one is loaded this cycle
            if (r_m_tvalid && i_m_axis_tready && (r_state != ST_OUT)) begin
                r_m_tvalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_key   <= in_key;
                        r_acc   <= r_capture_en;
                        r_idx   <= '0;
                        r_hits  <= '0;
                        r_fresh <= 1'b0;
                        r_full  <= 1'b0;
                        r_store <= 1'b0;
                        r_ptr   <= '0;
                        r_pend  <= 1'b0;
                        if (r_capture_en) begin
                            r_frames <= r_frames + 1'b1;
                            r_state  <= ST_SEARCH;
                        end else begin
                            r_state  <= ST_OUT;
                        end
                    end
                end
                ST_SEARCH: begin
                    if (key_hit) begin
                        r_idx   <= r_cand;
                        r_hits  <= hits_rd + 1'b1;
                        r_store <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= ST_WRITE;
                    end else if (r_ptr == r_used) begin
                        // every occupied entry compared: append or overflow
                        r_pend <= 1'b0;
                        if (r_used < CNT_W'(TABLE_ENTRIES)) begin
                            r_idx   <= r_used[IDX_W-1:0];
                            r_hits  <= CTR_W'(1);
                            r_fresh <= 1'b1;
                            r_store <= 1'b1;
                            r_used  <= r_used + 1'b1;
                        end else begin
                            r_full     <= 1'b1;
                            r_overflow <= r_overflow + 1'b1;
                        end
                        r_state <= ST_WRITE;
                    end else begin
                        r_cand <= rd_addr;
                        r_ptr  <= r_ptr + 1'b1;
                        r_pend <= 1'b1;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= {r_acc && r_record_en, r_overflow, r_frames,
                                       OUSED_W'(r_used), r_hits, r_full, r_fresh,
                                       OIDX_W'(r_idx), r_acc};
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = OUT_W'(r_m_tdata);

    // occupied count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("used count above table size");

    // search pointer never runs past the occupied entries
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEARCH) |-> (r_ptr <= r_used))
        else $error("search pointer past used entries");

    // an appended entry is never reported together with a full table
    a_fresh_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid |-> !(r_m_tdata[7] && r_m_tdata[8]))
        else $error("new entry and table full together");

    // a counted word bumps the frame total by one
    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && r_capture_en) |=> (r_frames == $past(r_frames) + 1'b1))
        else $error("frame total not advanced");

endmodule

// File: tb/probe_request_tracking_table_top_tb.sv
// ----------------------------------------------------------------------------
// probe_request_tracking_table_top_tb - self-checking bench for the probe table
// Drives parsed probe requests from a pending queue, tracks the table, hit
// counts and running totals in a local copy, and compares every result word
// field by field. Capture and record settings change between phases, and each
// phase uses one of four idle patterns on the request and result streams.
// ----------------------------------------------------------------------------
module probe_request_tracking_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W       = prtt_pkg::IN_W;
    localparam int OUT_W      = prtt_pkg::OUT_W;
    localparam int SLOTS      = prtt_pkg::TABLE_ENTRIES;
    localparam int NAME_MAX   = prtt_pkg::NAME_BYTES;
    localparam int KEY_POOL   = 96;
    localparam int RUN_LIMIT  = 1000000;
    localparam int SETTLE_CYC = 100;

    typedef struct packed {
        logic        accepted;
        logic [5:0]  slot;
        logic        fresh;
        logic        full;
        logic [31:0] hits;
        logic [6:0]  used;
        logic [31:0] frames;
        logic [31:0] overflows;
        logic        record;
    } t_probe_outcome;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic [IN_W-1:0]                 i_s_axis_tdata  = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [OUT_W-1:0]                o_m_axis_tdata;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic                            i_cfg_valid     = 1'b0;
    logic                            o_cfg_ready;
    logic [prtt_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [prtt_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    probe_request_tracking_table_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Local copy of the tracking table
    logic [47:0]  trk_addr [SLOTS];
    logic [5:0]   trk_len  [SLOTS];
    logic [255:0] trk_name [SLOTS];
    logic [31:0]  trk_hits [SLOTS];
    int unsigned  trk_used      = 0;
    logic [31:0]  trk_frames    = '0;
    logic [31:0]  trk_overflows = '0;
    logic         capture_on    = 1'b0;
    logic         record_on     = 1'b0;

    logic [47:0]  pool_addr [KEY_POOL];
    logic [5:0]   pool_len  [KEY_POOL];
    logic [255:0] pool_name [KEY_POOL];

    logic [IN_W-1:0] probe_pending_q [$];
    t_probe_outcome  outcome_expect_q [$];
    int unsigned     probes_queued  = 0;
    int unsigned     probes_taken   = 0;
    int unsigned     err_count      = 0;
    int unsigned     cycle_count    = 0;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    bit              s_taken        = 1'b0;

    function automatic logic [255:0] name_keep_mask(input int unsigned len);
        if (len >= NAME_MAX) begin
            return '1;
        end
        return (256'd1 << (8 * len)) - 256'd1;
    endfunction

    function automatic logic [255:0] rand_name();
        logic [255:0] n;
        for (int w = 0; w < 8; w++) begin
            n[32*w +: 32] = $urandom;
        end
        return n;
    endfunction

    function automatic logic [IN_W-1:0] pack_probe(input logic [47:0] addr,
                                                   input logic [5:0] len,
                                                   input logic [255:0] name,
                                                   input logic [3:0] chan,
                                                   input logic [7:0] sig,
                                                   input logic [31:0] tsec);
        return {6'b0, tsec, sig, chan, name, len, addr};
    endfunction

    // Search, update or append, and work out the result word
    function automatic t_probe_outcome track_probe(input logic [IN_W-1:0] word);
        t_probe_outcome o;
        logic [47:0]    addr;
        int unsigned    len;
        logic [255:0]   name;
        bit             hit;
        int unsigned    slot;
        o    = '0;
        hit  = 1'b0;
        slot = 0;
        addr = word[47:0];
        len  = word[53:48];
        if (len > NAME_MAX) begin
            len = NAME_MAX;
        end
        name = word[309:54] & name_keep_mask(len);
        if (capture_on) begin
            trk_frames = trk_frames + 32'd1;
            for (int i = 0; i < trk_used && !hit; i++) begin
                if (trk_addr[i] == addr && trk_len[i] == 6'(len) && trk_name[i] == name) begin
                    hit  = 1'b1;
                    slot = i;
                end
            end
            if (!hit && trk_used < SLOTS) begin
                slot           = trk_used;
                trk_addr[slot] = addr;
                trk_len[slot]  = 6'(len);
                trk_name[slot] = name;
                trk_hits[slot] = '0;
                trk_used       = trk_used + 1;
                o.fresh        = 1'b1;
                hit            = 1'b1;
            end
            if (hit) begin
                trk_hits[slot] = trk_hits[slot] + 32'd1;
                o.hits         = trk_hits[slot];
            end else begin
                trk_overflows = trk_overflows + 32'd1;
                o.full        = 1'b1;
                slot          = 0;
            end
            o.accepted = 1'b1;
            o.slot     = 6'(slot);
            o.record   = record_on;
        end
        o.used      = 7'(trk_used);
        o.frames    = trk_frames;
        o.overflows = trk_overflows;
        return o;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // Request driver: hold the word until taken, then advance or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || s_taken) begin
            if (probe_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_s_axis_tdata  <= probe_pending_q.pop_front();
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: register writes, accepted requests and result words
    always @(posedge i_clk) begin
        t_probe_outcome want;
        t_probe_outcome got;
        if (!i_rst_n) begin
            s_taken = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    prtt_pkg::CFG_CAPTURE: capture_on = i_cfg_data[0];
                    prtt_pkg::CFG_RECORD:  record_on  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.accepted  = o_m_axis_tdata[0];
                got.slot      = o_m_axis_tdata[6:1];
                got.fresh     = o_m_axis_tdata[7];
                got.full      = o_m_axis_tdata[8];
                got.hits      = o_m_axis_tdata[40:9];
                got.used      = o_m_axis_tdata[47:41];
                got.frames    = o_m_axis_tdata[79:48];
                got.overflows = o_m_axis_tdata[111:80];
                got.record    = o_m_axis_tdata[112];
                if (outcome_expect_q.size() == 0) begin
                    $display("%0t ns: result word with none expected, expected none actual %0h",
                             $time, o_m_axis_tdata);
                    err_count++;
                end else begin
                    want = outcome_expect_q.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("entry_index", want.slot, got.slot);
                    check_field("is_new_entry", want.fresh, got.fresh);
                    check_field("table_full", want.full, got.full);
                    check_field("entry_hits", want.hits, got.hits);
                    check_field("entries_used", want.used, got.used);
                    check_field("frames_total", want.frames, got.frames);
                    check_field("overflow_total", want.overflows, got.overflows);
                    check_field("record_frame", want.record, got.record);
                end
            end
            s_taken = i_s_axis_tvalid && o_s_axis_tready;
            if (s_taken) begin
                outcome_expect_q.push_back(track_probe(i_s_axis_tdata));
                probes_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("FAIL probe_request_tracking_table_top");
            $finish;
        end
    end

    task automatic queue_probe(input logic [IN_W-1:0] word);
        probe_pending_q.push_back(word);
        probes_queued++;
    endtask

    task automatic wait_drained();
        while (probes_taken != probes_queued || outcome_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input prtt_pkg::t_cfg_reg idx, input logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly known keys with junk past the length, some near misses, some noise
    function automatic logic [IN_W-1:0] random_probe();
        int unsigned  pick;
        int unsigned  k;
        int unsigned  len;
        logic [47:0]  addr;
        logic [255:0] name;
        logic [255:0] keep;
        pick = $urandom_range(99);
        k    = $urandom_range(KEY_POOL - 1);
        addr = pool_addr[k];
        len  = pool_len[k];
        name = pool_name[k];
        if (pick >= 85) begin
            addr = {16'($urandom), 32'($urandom)};
            len  = $urandom_range(63);
            name = rand_name();
        end else begin
            if (pick >= 70) begin
                case ($urandom_range(2))
                    0: addr = addr ^ (48'd1 << $urandom_range(47));
                    1: len  = (len == 0) ? 1 : len - 1;
                    default: begin
                        if (len != 0) begin
                            name = name ^ (256'd1 << $urandom_range(8 * len - 1));
                        end else begin
                            len = $urandom_range(1, NAME_MAX);
                        end
                    end
                endcase
            end
            keep = name_keep_mask(len);
            name = (name & keep) | (rand_name() & ~keep);
            if (len == NAME_MAX && $urandom_range(1)) begin
                len = $urandom_range(NAME_MAX + 1, 63);
            end
        end
        return pack_probe(addr, 6'(len), name, 4'($urandom_range(15)), 8'($urandom),
                          $urandom);
    endfunction

    initial begin
        logic [47:0]  base_addr;
        logic [255:0] nm;
        int unsigned  keep_len;
        int unsigned  len_set [6];
        bit           cap_set [8];
        bit           rec_set [8];
        len_set = '{1, 8, 9, 24, 25, 31};
        cap_set = '{1, 1, 0, 1, 1, 0, 1, 1};
        rec_set = '{0, 1, 1, 1, 0, 0, 1, 0};

        // Key pool: every fourth key shares its address with the one before
        for (int k = 0; k < KEY_POOL; k++) begin
            if (k % 4 == 3) begin
                pool_addr[k] = pool_addr[k-1];
            end else begin
                pool_addr[k] = {16'($urandom), 32'($urandom)};
            end
            if (k < 16) begin
                keep_len = (k % 8 == 0) ? 0 : (k % 8 == 1) ? NAME_MAX : $urandom_range(NAME_MAX);
            end else begin
                keep_len = $urandom_range(NAME_MAX);
            end
            pool_len[k]  = 6'(keep_len);
            pool_name[k] = rand_name() & name_keep_mask(keep_len);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Capture still off from reset: nothing is counted
        queue_probe(pack_probe('1, '1, '1, '1, '1, '1));
        queue_probe(pack_probe('0, '0, '0, '0, '0, '0));
        wait_drained();
        repeat (SETTLE_CYC) @(negedge i_clk);
        write_reg(prtt_pkg::CFG_CAPTURE, 1'b1);
        write_reg(prtt_pkg::CFG_RECORD, 1'b1);

        // Wildcard name: bytes are ignored
        queue_probe(pack_probe('0, 6'd0, '0, 4'd0, 8'd0, 32'd0));
        queue_probe(pack_probe('0, 6'd0, rand_name(), 4'd15, 8'hff, 32'd1));
        // Full-length names and saturation of an over-long length
        queue_probe(pack_probe('1, 6'd32, '1, 4'd15, 8'h7f, '1));
        queue_probe(pack_probe('1, 6'd63, '1, 4'd0, 8'h80, 32'd0));
        queue_probe(pack_probe('1, 6'd33, '1, 4'd7, 8'h00, 32'h8000_0000));
        queue_probe(pack_probe('1, 6'd31, '1, 4'd3, 8'h01, 32'd5));
        queue_probe(pack_probe('1, 6'd31, {8'h00, {248{1'b1}}}, 4'd9, 8'hfe, 32'd6));
        queue_probe(pack_probe('1, 6'd32, {8'h00, {248{1'b1}}}, 4'd1, 8'h40, 32'd7));
        // Partial names: a repeat with junk past the length must hit
        base_addr = {16'($urandom), 32'($urandom)};
        foreach (len_set[j]) begin
            nm = rand_name();
            queue_probe(pack_probe(base_addr, 6'(len_set[j]), nm, 4'($urandom_range(15)),
                                   8'($urandom), $urandom));
            nm = (nm & name_keep_mask(len_set[j])) | (rand_name() & ~name_keep_mask(len_set[j]));
            queue_probe(pack_probe(base_addr, 6'(len_set[j]), nm, 4'($urandom_range(15)),
                                   8'($urandom), $urandom));
        end
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            repeat (SETTLE_CYC) @(negedge i_clk);
            write_reg(prtt_pkg::CFG_CAPTURE, cap_set[ph]);
            write_reg(prtt_pkg::CFG_RECORD, rec_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            repeat (cap_set[ph] ? 140 : 30) begin
                queue_probe(random_probe());
            end
            wait_drained();
        end

        repeat (SETTLE_CYC) @(negedge i_clk);
        if (err_count == 0 && outcome_expect_q.size() == 0) begin
            $display("PASS probe_request_tracking_table_top");
        end else begin
            $display("FAIL probe_request_tracking_table_top");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/prtt_pkg.sv
rtl/core/prtt_ram.sv
rtl/core/probe_request_tracking_table_top.sv
tb/probe_request_tracking_table_top_tb.sv
